### hdl/rational_arithmetic_unit_top_macros.svh
// Assertion macros shared by the rational arithmetic unit RTL.
`ifndef RATIONAL_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_TOP_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define RAU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define RAU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/rau_pkg.sv
// Package: types, codes and constants of the rational arithmetic unit.
package rau_pkg;

    localparam int WIDTH = 32;

    localparam logic [2:0] KIND_ADD = 3'd0;
    localparam logic [2:0] KIND_SUB = 3'd1;
    localparam logic [2:0] KIND_MUL = 3'd2;
    localparam logic [2:0] KIND_DIV = 3'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [1:0] ORD_LESS    = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_GREATER = 2'd2;

    // largest positive reduced value, 2^(WIDTH-1)-1
    localparam logic [63:0] MAX_POS = (64'd1 << (WIDTH - 1)) - 64'd1;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_CMP
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_COMB,
        S_GCD,
        S_DIVM,
        S_DIVD,
        S_FIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } t_req;

    typedef struct packed {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic [1:0]         order;
        logic [1:0]         status;
    } t_result;

endpackage

### hdl/rational_arithmetic_unit_top.sv
// Top level of the rational arithmetic unit: handshakes and result register.
//
// Input channel: i_in_valid with i_kind, i_a_num, i_a_den, i_b_num, i_b_den;
// an item is taken at a clock edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid with o_res_num, o_res_den, o_order, o_status;
// an item leaves at an edge with o_out_valid high and i_out_stall low.
// One item is worked on at a time; o_in_stall is high while it is in flight.
// For add, sub, mul and div: products on the one shared 32x32 multiplier,
// a combine step, a binary gcd on a shared 64-bit subtractor, then two
// 64-bit restoring divisions on that subtractor and a range check, then the
// result register. Compare uses the products and the combine step only. A
// zero denominator (or divide by zero) goes from idle straight to done.
// The next item can be taken in the cycle after the core hands its result
// to the result register.
// The result register lets the next item be taken while a finished
// result waits; a stalled receiver holds the result steady, and the core
// then waits with its own result until the register frees.
// Reset (i_rst_n low, synchronous) empties the result register and returns
// the sequencer to idle. No state is carried between items.
`include "rational_arithmetic_unit_top_macros.svh"

module rational_arithmetic_unit_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_kind,
    input  logic signed [31:0] i_a_num,
    input  logic signed [31:0] i_a_den,
    input  logic signed [31:0] i_b_num,
    input  logic signed [31:0] i_b_den,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_res_num,
    output logic [30:0]        o_res_den,
    output logic [1:0]         o_order,
    output logic [1:0]         o_status
);
    import rau_pkg::*;

    t_req    req;
    t_result core_res;
    t_result r_out;
    logic    r_out_valid;
    logic    core_idle, core_done, take, in_acc;

    assign req    = '{kind: i_kind, a_num: i_a_num, a_den: i_a_den,
                      b_num: i_b_num, b_den: i_b_den};
    assign in_acc = i_in_valid && core_idle;
    // result register free now or emptied this cycle
    assign take   = core_done && (!r_out_valid || !i_out_stall);

    rau_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc),
        .i_req   (req),
        .i_take  (take),
        .o_idle  (core_idle),
        .o_done  (core_done),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= core_res;
        end
    end

    assign o_in_stall  = !core_idle;
    assign o_out_valid = r_out_valid;
    assign o_res_num   = r_out.num;
    assign o_res_den   = r_out.den;
    assign o_order     = r_out.order;
    assign o_status    = r_out.status;

    `RAU_ASSERT_NEXT(a_busy_after_accept, in_acc, o_in_stall, "not busy after accept")
    `RAU_ASSERT_NOW(a_err_zeroed, o_out_valid && (o_status != ST_OK),
        (o_res_num == 32'sd0) && (o_res_den == 31'd0), "error result not zeroed")
    `RAU_ASSERT_NOW(a_order_cmp_only, o_out_valid && (o_order != ORD_LESS),
        (o_res_den == 31'd0) && (o_status == ST_OK), "order set on arithmetic result")
    `RAU_ASSERT_NOW(a_zero_den_ok, o_out_valid && (o_status == ST_OK) && (o_res_den == 31'd0),
        o_res_num == 32'sd0, "zero denominator on ok fraction")
endmodule

### hdl/rau_mul.sv
// Registered 32 x 32 unsigned multiplier shared by all product steps.
module rau_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= {32'd0, i_a} * {32'd0, i_b};
    end

    assign o_p = r_p;
endmodule

### hdl/rau_seq.sv
// Sequencer and datapath: products, binary gcd, exact restoring divisions.
module rau_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  rau_pkg::t_req   i_req,
    input  logic            i_take,
    output logic            o_idle,
    output logic            o_done,
    output rau_pkg::t_result o_res
);
    import rau_pkg::*;

    t_state      r_state, n_state;
    t_op         r_op;
    logic [31:0] r_ma, r_mb, r_da, r_db;
    logic        r_sa, r_sb, r_neg;
    logic [1:0]  r_step;
    logic [63:0] r_x, r_y, r_z;
    logic [63:0] r_mag, r_den, r_gu, r_gv, r_n, r_rem;
    logic [5:0]  r_k, r_cnt;
    t_result     r_res;

    // operand decode at start
    t_op         in_op;
    logic [31:0] in_ma, in_mb, in_da, in_db;
    logic        in_err;

    always_comb begin
        in_ma = i_req.a_num[31] ? 32'(-i_req.a_num) : 32'(i_req.a_num);
        in_mb = i_req.b_num[31] ? 32'(-i_req.b_num) : 32'(i_req.b_num);
        in_da = i_req.a_den[31] ? 32'(-i_req.a_den) : 32'(i_req.a_den);
        in_db = i_req.b_den[31] ? 32'(-i_req.b_den) : 32'(i_req.b_den);
        case (i_req.kind)
            KIND_ADD: in_op = OP_ADD;
            KIND_SUB: in_op = OP_SUB;
            KIND_MUL: in_op = OP_MUL;
            KIND_DIV: in_op = OP_DIV;
            default:  in_op = OP_CMP;
        endcase
        in_err = (i_req.a_den == 32'sd0) || (i_req.b_den == 32'sd0) ||
                 ((in_op == OP_DIV) && (i_req.b_num == 32'sd0));
    end

    // multiplier operand select per step
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    always_comb begin
        case (r_step)
            2'd0: begin
                mul_a = r_ma;
                mul_b = (r_op == OP_MUL) ? r_mb : r_db;
            end
            2'd1: begin
                mul_a = r_mb;
                mul_b = r_da;
            end
            default: begin
                mul_a = r_da;
                mul_b = (r_op == OP_DIV) ? r_mb : r_db;
            end
        endcase
    end

    rau_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // signed combine of the two cross products
    logic [65:0] s1, s2, s_sum, s_neg;
    logic        flip;

    always_comb begin
        flip  = r_sb ^ ((r_op == OP_SUB) || (r_op == OP_CMP));
        s1    = r_sa ? (66'd0 - {2'b00, r_x}) : {2'b00, r_x};
        s2    = flip ? (66'd0 - {2'b00, r_y}) : {2'b00, r_y};
        s_sum = s1 + s2;
        s_neg = 66'd0 - s_sum;
    end

    // shared subtractor: gcd step or division step
    logic [64:0] sub_a, sub_b, div_sh;
    logic [65:0] sub_d;
    logic        q_bit;
    logic [63:0] div_rem, div_q;

    always_comb begin
        div_sh = {r_rem, r_n[63]};
        if (r_state == S_GCD) begin
            sub_a = {1'b0, r_gu};
            sub_b = {1'b0, r_gv};
        end else begin
            sub_a = div_sh;
            sub_b = {1'b0, r_gv};
        end
        sub_d   = {1'b0, sub_a} - {1'b0, sub_b};
        q_bit   = !sub_d[65];
        div_rem = q_bit ? sub_d[63:0] : div_sh[63:0];
        div_q   = {r_n[62:0], q_bit};
    end

    // range check of the reduced result
    logic        fin_neg, fin_ovf;
    logic [63:0] fin_num;

    always_comb begin
        fin_neg = r_neg && (r_mag != 64'd0);
        fin_ovf = (r_mag > (fin_neg ? (MAX_POS + 64'd1) : MAX_POS)) || (r_n > MAX_POS);
        fin_num = fin_neg ? (64'd0 - r_mag) : r_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_idle  = (r_state == S_IDLE);
        o_done  = (r_state == S_DONE);
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = in_err ? S_DONE : S_MUL;
                end
            end
            S_MUL: begin
                if (r_step == 2'd3) begin
                    n_state = S_COMB;
                end
            end
            S_COMB: begin
                n_state = (r_op == OP_CMP) ? S_DONE : S_GCD;
            end
            S_GCD: begin
                if (r_gu == 64'd0) begin
                    n_state = S_DIVM;
                end
            end
            S_DIVM: begin
                if (r_cnt == 6'd63) begin
                    n_state = S_DIVD;
                end
            end
            S_DIVD: begin
                if (r_cnt == 6'd63) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_op   <= in_op;
                    r_ma   <= in_ma;
                    r_mb   <= in_mb;
                    r_da   <= in_da;
                    r_db   <= in_db;
                    r_sa   <= i_req.a_num[31] ^ i_req.a_den[31];
                    r_sb   <= i_req.b_num[31] ^ i_req.b_den[31];
                    r_step <= 2'd0;
                    r_res  <= '{num: 32'sd0, den: 31'd0, order: ORD_LESS,
                                status: ST_ZERO_DEN};
                end
            end
            S_MUL: begin
                r_step <= r_step + 2'd1;
                case (r_step)
                    2'd1:    r_x <= mul_p;
                    2'd2:    r_y <= mul_p;
                    2'd3:    r_z <= mul_p;
                    default: ;
                endcase
            end
            S_COMB: begin
                if ((r_op == OP_ADD) || (r_op == OP_SUB)) begin
                    r_neg <= s_sum[65];
                    r_mag <= s_sum[65] ? s_neg[63:0] : s_sum[63:0];
                    r_gu  <= s_sum[65] ? s_neg[63:0] : s_sum[63:0];
                end else begin
                    r_neg <= r_sa ^ r_sb;
                    r_mag <= r_x;
                    r_gu  <= r_x;
                end
                r_den <= r_z;
                r_gv  <= r_z;
                r_k   <= 6'd0;
                r_res <= '{num: 32'sd0, den: 31'd0,
                           order: s_sum[65] ? ORD_LESS :
                                  ((s_sum == 66'd0) ? ORD_EQUAL : ORD_GREATER),
                           status: ST_OK};
            end
            S_GCD: begin
                if (r_gu == 64'd0) begin
                    r_n   <= r_mag >> r_k;
                    r_rem <= 64'd0;
                    r_cnt <= 6'd0;
                end else if (!r_gu[0] && !r_gv[0]) begin
                    r_gu <= r_gu >> 1;
                    r_gv <= r_gv >> 1;
                    r_k  <= r_k + 6'd1;
                end else if (!r_gu[0]) begin
                    r_gu <= r_gu >> 1;
                end else if (!r_gv[0]) begin
                    r_gv <= r_gv >> 1;
                end else if (!q_bit) begin
                    // both odd, gu below gv: swap
                    r_gu <= r_gv;
                    r_gv <= r_gu;
                end else begin
                    r_gu <= sub_d[64:1];
                end
            end
            S_DIVM: begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_mag <= div_q;
                    r_n   <= r_den >> r_k;
                    r_rem <= 64'd0;
                end else begin
                    r_n   <= div_q;
                    r_rem <= div_rem;
                end
            end
            S_DIVD: begin
                r_cnt <= r_cnt + 6'd1;
                r_n   <= div_q;
                r_rem <= div_rem;
            end
            S_FIN: begin
                if (fin_ovf) begin
                    r_res <= '{num: 32'sd0, den: 31'd0, order: ORD_LESS,
                               status: ST_OVERFLOW};
                end else begin
                    r_res <= '{num: fin_num[31:0], den: r_n[30:0], order: ORD_LESS,
                               status: ST_OK};
                end
            end
            default: ;
        endcase
    end

    assign o_res = r_res;
endmodule

### tb/rational_arithmetic_unit_top_tb.sv
// Testbench for the rational arithmetic unit: random and corner fractions, scoreboard check.
module rational_arithmetic_unit_top_tb;
    import rau_pkg::*;

    // expected result of one fraction operation
    typedef struct {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic [1:0]         order;
        logic [1:0]         status;
    } t_expect;

    // Fraction predictor and queue of pending results.
    class frac_scoreboard;
        t_expect pending[$];
        int      errors;

        function longint unsigned gcd_u(longint unsigned x, longint unsigned y);
            longint unsigned t;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            return x;
        endfunction

        function longint unsigned mag(longint v);
            return v < 0 ? 64'd0 - longint'(v) : longint'(v);
        endfunction

        // reduce by gcd, then range-check against WIDTH bits
        function t_expect reduce(bit neg, longint unsigned m, longint unsigned d);
            t_expect         e;
            longint unsigned g;
            longint unsigned lim;
            e = '{0, 0, ORD_LESS, ST_OK};
            g = gcd_u(m, d);
            if (g != 0) begin
                m = m / g;
                d = d / g;
            end
            if (m == 0) neg = 0;
            lim = neg ? MAX_POS + 1 : MAX_POS;
            if (m > lim || d > MAX_POS) begin
                e.status = ST_OVERFLOW;
                return e;
            end
            e.num = neg ? 32'(64'd0 - m) : 32'(m);
            e.den = 31'(d);
            return e;
        endfunction

        function void note_request(logic [2:0] kind, logic signed [31:0] an,
                                   logic signed [31:0] ad, logic signed [31:0] bn,
                                   logic signed [31:0] bd);
            t_expect         e;
            longint          na, da, nb, db, t1, t2, p, l, r, s;
            longint unsigned g, den, m;
            bit              neg;
            na = an; da = ad; nb = bn; db = bd;
            e = '{0, 0, ORD_LESS, ST_OK};
            if (da == 0 || db == 0) begin
                e.status = ST_ZERO_DEN;
            end else begin
                if (da < 0) begin na = -na; da = -da; end
                if (db < 0) begin nb = -nb; db = -db; end
                if (kind == KIND_ADD || kind == KIND_SUB) begin
                    g   = gcd_u(da, db);
                    t1  = na * longint'(db / g);
                    t2  = nb * longint'(da / g);
                    den = (da / g) * db;
                    if (kind == KIND_SUB) t2 = -t2;
                    if (t1 >= 0 && t2 >= 0) begin
                        neg = 0; m = t1 + t2;
                    end else if (t1 < 0 && t2 < 0) begin
                        neg = 1; m = mag(t1) + mag(t2);
                    end else begin
                        s = t1 + t2; neg = s < 0; m = mag(s);
                    end
                    e = reduce(neg, m, den);
                end else if (kind == KIND_MUL) begin
                    p = na * nb;
                    e = reduce(p < 0, mag(p), da * db);
                end else if (kind == KIND_DIV) begin
                    if (nb == 0) begin
                        e.status = ST_ZERO_DEN;
                    end else begin
                        p = na * db;
                        e = reduce((p < 0) != (nb < 0), mag(p), da * mag(nb));
                    end
                end else begin
                    // compare, also any undefined kind
                    l = na * db;
                    r = nb * da;
                    e.order = l < r ? ORD_LESS : (l == r ? ORD_EQUAL : ORD_GREATER);
                end
            end
            pending.push_back(e);
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_result(logic signed [31:0] num, logic [30:0] den,
                          logic [1:0] order, logic [1:0] status);
            t_expect e;
            if (pending.size() == 0) begin
                report("unexpected result");
                return;
            end
            e = pending.pop_front();
            if (num !== e.num)
                report($sformatf("num got %0d want %0d", num, e.num));
            if (den !== e.den)
                report($sformatf("den got %0d want %0d", den, e.den));
            if (order !== e.order)
                report($sformatf("order got %0d want %0d", order, e.order));
            if (status !== e.status)
                report($sformatf("status got %0d want %0d", status, e.status));
        endtask
    endclass

    localparam int WATCHDOG = 20000;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_in_valid = 0;
    logic               o_in_stall;
    logic [2:0]         i_kind = '0;
    logic signed [31:0] i_a_num = '0;
    logic signed [31:0] i_a_den = '0;
    logic signed [31:0] i_b_num = '0;
    logic signed [31:0] i_b_den = '0;
    logic               o_out_valid;
    logic               i_out_stall = 0;
    logic signed [31:0] o_res_num;
    logic [30:0]        o_res_den;
    logic [1:0]         o_order;
    logic [1:0]         o_status;

    frac_scoreboard sb = new();
    int send_idle_pct = 15;   // chance in a hundred that the sender holds off
    int recv_stall_pct = 54;  // chance in a hundred that the receiver stalls
    int quiet_cycles = 0;

    rational_arithmetic_unit_top dut (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    // Receiver: random stall, check every accepted item.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_res_num, o_res_den, o_order, o_status);
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: cycles with no item moved on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offer one item; hold it steady until taken, with random gaps before it.
    task automatic send_item(logic [2:0] kind, logic [31:0] an, logic [31:0] ad,
                             logic [31:0] bn, logic [31:0] bd);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_kind  <= kind;
        i_a_num <= an;
        i_a_den <= ad;
        i_b_num <= bn;
        i_b_den <= bd;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(kind, an, ad, bn, bd);
    endtask

    // Mostly small magnitudes so results stay in range; sometimes full width.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0:       return $urandom();
            1:       return $urandom_range(2) == 0 ? 32'h8000_0000 :
                            ($urandom_range(1) ? 32'h7fff_ffff : 32'hffff_ffff);
            2:       return 32'($signed($urandom_range(2000)) - 1000);
            3:       return 32'($signed($urandom_range(131072)) - 65536);
            default: return 32'($signed($urandom_range(40)) - 20);
        endcase
    endfunction

    task automatic run_random(int count);
        logic [31:0] ad, bd;
        repeat (count) begin
            ad = pick_value();
            bd = pick_value();
            // rare zero denominators; most items valid
            if ($urandom_range(30) != 0 && ad == 0) ad = 1;
            if ($urandom_range(30) != 0 && bd == 0) bd = 7;
            send_item(3'($urandom_range(7)), pick_value(), ad, pick_value(), bd);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: each operation, sign cases, zero denominators, divide by zero,
        // extremes and overflow.
        send_item(KIND_ADD, 1, 2, 1, 3);
        send_item(KIND_SUB, 1, 2, 1, 2);
        send_item(KIND_MUL, -3, 4, 2, -9);
        send_item(KIND_DIV, 3, 4, -3, 8);
        send_item(OP_CMP, 1, 3, 1, 2);
        send_item(OP_CMP, 2, 4, 1, 2);
        send_item(OP_CMP, 1, -2, 1, -3);
        send_item(3'd5, 5, 1, 4, 1);
        send_item(3'd6, 0, 1, 0, 1);
        send_item(3'd7, -1, 1, 1, 1);
        send_item(KIND_ADD, 1, 0, 1, 1);
        send_item(KIND_MUL, 1, 1, 1, 0);
        send_item(KIND_DIV, 1, 2, 0, 5);
        send_item(KIND_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
        send_item(KIND_SUB, 32'h8000_0000, 1, 0, 1);
        send_item(KIND_MUL, 32'h8000_0000, 1, -1, 1);
        send_item(KIND_MUL, 32'h8000_0000, 32'h8000_0000, 1, 1);
        send_item(KIND_DIV, 1, 32'h7fff_ffff, 32'h8000_0000, 1);
        send_item(KIND_ADD, 1, 32'h7fff_ffff, 1, 32'h7fff_fffe);
        send_item(OP_CMP, 32'h8000_0000, 1, 32'h7fff_ffff, 32'h8000_0000);
        send_item(KIND_ADD, 0, -5, 0, 7);
        send_item(KIND_SUB, -6, -4, 3, 2);

        // Random, with three idling regimes.
        run_random(560);
        send_idle_pct = 54; recv_stall_pct = 15;
        run_random(560);
        send_idle_pct = 0; recv_stall_pct = 0;
        run_random(560);
        i_in_valid <= 0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
